[hdl/iad_pkg.sv]
// Package for the integer to ASCII digit converter.
// Holds shared widths, the digit character table and the control types.
// No dependencies.
package iad_pkg;

   // Field widths of the input and result words.
   localparam int VALUE_W  = 64;
   localparam int CHAR_W   = 7;

   // Digit shift register geometry.
   localparam int NIB_W    = 4;
   localparam int HEX_DIGS = VALUE_W / NIB_W;
   localparam int CNT_W    = $clog2(HEX_DIGS + 1);

   // Decimal conversion geometry: 32 binary bits give at most ten BCD digits.
   localparam int DEC_BITS = 32;
   localparam int DEC_DIGS = 10;
   localparam int BCD_W    = DEC_DIGS * NIB_W;
   localparam int PAD_W    = VALUE_W - BCD_W;
   localparam int STEP_W   = $clog2(DEC_BITS);

   // Digit code to ASCII character.
   localparam logic [CHAR_W-1:0] DIGIT_CHARS [HEX_DIGS] = '{
      7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
   };

   // Top-level sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DEC  = 3'b010,
      ST_OUT  = 3'b100
   } iad_state_type;

   // Load command from the sequencer to the digit emitter.
   typedef struct packed {
      logic               load;
      logic [VALUE_W-1:0] digits;
      logic [CNT_W-1:0]   count;
   } iad_load_type;

endpackage

[hdl/integer_to_ascii_digits.sv]
// Top level of the integer to ASCII digit converter.
// Depends on iad_pkg, iad_bcd and iad_emit.
//
// One input word (req_func, req_value) yields one result word per digit, most
// significant first, with rsp_last_digit on the final one; leading zeros are
// dropped and zero gives a single '0'. req_stall stays high from acceptance
// until the last digit is taken. In hex mode the nibble shifter skips one
// leading zero per cycle and then sends the digits. Decimal mode first runs
// the bit-serial shift-and-add-three converter, then hands the result over
// to the shifter, which works over ten BCD digits.
module integer_to_ascii_digits (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [iad_pkg::VALUE_W-1:0]   req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [iad_pkg::CHAR_W-1:0]    rsp_digit_char,
   output logic                          rsp_last_digit
);
   import iad_pkg::*;

   iad_state_type    state_ff, state_in;
   iad_load_type     cmd;
   logic             accept;
   logic             bcd_start;
   logic             bcd_done;
   logic [BCD_W-1:0] bcd;
   logic             finished;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign bcd_start = accept && !req_func;

   // Load the emitter straight from the input in hex mode, from BCD otherwise.
   always_comb begin
      cmd.load = (accept && req_func) || ((state_ff == ST_DEC) && bcd_done);
      if (state_ff == ST_IDLE) begin
         cmd.digits = req_value;
         cmd.count  = CNT_W'(HEX_DIGS);
      end else begin
         cmd.digits = {bcd, {PAD_W{1'b0}}};
         cmd.count  = CNT_W'(DEC_DIGS);
      end
   end

   // Sequencer: idle, decimal conversion, digit output.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = req_func ? ST_OUT : ST_DEC;
            end
         end
         ST_DEC: begin
            if (bcd_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (finished) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   iad_bcd u_bcd (
      .clock (clock),
      .reset (reset),
      .start (bcd_start),
      .bin   (req_value[DEC_BITS-1:0]),
      .done  (bcd_done),
      .bcd   (bcd)
   );

   iad_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit),
      .finished       (finished)
   );

endmodule

[hdl/iad_bcd.sv]
// Bit-serial binary to BCD converter (shift and add-three), one bit per cycle.
// Depends on iad_pkg.
module iad_bcd (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [iad_pkg::DEC_BITS-1:0] bin,
   output logic                       done,
   output logic [iad_pkg::BCD_W-1:0]  bcd
);
   import iad_pkg::*;

   logic [DEC_BITS-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]    bcd_ff, bcd_in, bcd_adj;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   // Add three to every BCD digit of five or more before the next shift.
   always_comb begin
      for (int i = 0; i < DEC_DIGS; i++) begin
         if (bcd_ff[i*NIB_W +: NIB_W] >= NIB_W'(5)) begin
            bcd_adj[i*NIB_W +: NIB_W] = bcd_ff[i*NIB_W +: NIB_W] + NIB_W'(3);
         end else begin
            bcd_adj[i*NIB_W +: NIB_W] = bcd_ff[i*NIB_W +: NIB_W];
         end
      end
   end

   // Shift one binary bit into the BCD register per cycle.
   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in  = bin;
         bcd_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bin_in  = {bin_ff[DEC_BITS-2:0], 1'b0};
         bcd_in  = {bcd_adj[BCD_W-2:0], bin_ff[DEC_BITS-1]};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DEC_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

[hdl/iad_emit.sv]
// Digit emitter: a nibble shift register that drops leading zeros and
// sends one ASCII character per word. Depends on iad_pkg.
module iad_emit (
   input  logic                       clock,
   input  logic                       reset,
   input  iad_pkg::iad_load_type      cmd,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [iad_pkg::CHAR_W-1:0] rsp_digit_char,
   output logic                       rsp_last_digit,
   output logic                       finished
);
   import iad_pkg::*;

   logic [VALUE_W-1:0] digits_ff, digits_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               active_ff, active_in;
   logic               started_ff, started_in;
   logic [NIB_W-1:0]   top_nib;
   logic               skipping;
   logic               last;
   logic               sent;

   // The next digit always sits in the top nibble. Zeros are dropped only
   // until the first digit has gone out; inner zeros are sent.
   assign top_nib  = digits_ff[VALUE_W-1 -: NIB_W];
   assign last     = (count_ff == CNT_W'(1));
   assign skipping = !started_ff && (top_nib == '0) && !last;
   assign rsp_valid      = active_ff && !skipping;
   assign rsp_digit_char = DIGIT_CHARS[top_nib];
   assign rsp_last_digit = last;
   assign sent     = rsp_valid && !rsp_stall;
   assign finished = sent && last;

   // Shift one nibble on a skipped leading zero or on a sent word.
   always_comb begin
      digits_in  = digits_ff;
      count_in   = count_ff;
      active_in  = active_ff;
      started_in = started_ff;
      if (cmd.load) begin
         digits_in  = cmd.digits;
         count_in   = cmd.count;
         active_in  = 1'b1;
         started_in = 1'b0;
      end else if (active_ff && (skipping || sent)) begin
         digits_in = {digits_ff[VALUE_W-NIB_W-1:0], {NIB_W{1'b0}}};
         count_in  = count_ff - CNT_W'(1);
         if (sent) begin
            started_in = 1'b1;
         end
         if (finished) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         started_ff <= 1'b0;
      end else begin
         active_ff  <= active_in;
         started_ff <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff <= digits_in;
      count_ff  <= count_in;
   end

endmodule

[hdl/iad_checker.sv]
// Port-level checker for the integer to ASCII digit converter, and its bind.
// Depends on iad_pkg and integer_to_ascii_digits.
module iad_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [iad_pkg::CHAR_W-1:0]    rsp_digit_char,
   input logic                          rsp_last_digit
);
   import iad_pkg::*;

   // No result word is offered right after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word offered after reset");

   // An accepted input word holds off the next one.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after accepting a word");

   // No new input word is taken while digits are still pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted while digits pending");

   // Every character is a decimal digit or an upper-case hex letter.
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_digit_char >= 7'h30 && rsp_digit_char <= 7'h39) ||
                     (rsp_digit_char >= 7'h41 && rsp_digit_char <= 7'h46)))
      else $error("digit character out of range");

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_digit_char) &&
                                    $stable(rsp_last_digit)))
      else $error("stalled result word changed");

endmodule

bind integer_to_ascii_digits iad_checker u_iad_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_digit_char (rsp_digit_char),
   .rsp_last_digit (rsp_last_digit)
);

[tb/tb_integer_to_ascii_digits.sv]
// Self-checking testbench for the integer to ASCII digit converter.
// Depends on iad_pkg and integer_to_ascii_digits; predicts each digit word in
// place and compares every accepted result word against the oldest prediction.
module tb_integer_to_ascii_digits;
   timeunit 1ns;
   timeprecision 1ps;

   import iad_pkg::*;

   // Format select codes for req_func.
   localparam logic FMT_DEC = 1'b0;
   localparam logic FMT_HEX = 1'b1;

   // Cycles that cover one decimal conversion with room to spare.
   localparam int SETTLE_CYCLES = 60;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } digit_word_type;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_func  = 1'b0;
   logic [VALUE_W-1:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [CHAR_W-1:0]  rsp_digit_char;
   logic               rsp_last_digit;

   digit_word_type pending_digits[$];
   int          digit_mismatches = 0;
   bit          send_gaps_on     = 1'b1;
   bit          stall_gaps_on    = 1'b1;
   int          rsp_hold_left    = 0;

   integer_to_ascii_digits dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Work out the digit words for one number and queue them, most
   // significant first, with the last flag on the final digit.
   function automatic void queue_digits(input logic hex_mode,
                                        input logic [VALUE_W-1:0] number);
      logic [CHAR_W-1:0]  rev [HEX_DIGS];
      logic [VALUE_W-1:0] rest;
      logic [3:0]         d;
      int                 n;
      digit_word_type     w;
      n    = 0;
      rest = hex_mode ? number : {32'h0, number[31:0]};
      do begin
         d      = hex_mode ? rest[3:0] : 4'(rest % 10);
         rev[n] = (d < 10) ? CHAR_W'(8'h30 + d) : CHAR_W'(8'h41 + d - 10);
         n++;
         rest   = hex_mode ? (rest >> 4) : (rest / 10);
      end while (rest != 0 && n < HEX_DIGS);
      for (int k = n - 1; k >= 0; k--) begin
         w.ch   = rev[k];
         w.last = (k == 0);
         pending_digits.push_back(w);
      end
   endfunction

   // Offer one word at the falling edge, with random gaps before it, and
   // queue its digits once the block takes it.
   task automatic send_number(input logic hex_mode, input logic [VALUE_W-1:0] number);
      @(negedge clock);
      while (send_gaps_on && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= hex_mode;
      req_value <= number;
      do @(posedge clock); while (req_stall);
      queue_digits(hex_mode, number);
   endtask

   task automatic release_input;
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_all_digits;
      while (pending_digits.size() != 0) @(posedge clock);
   endtask

   // Mostly well spread digit counts; decimal words often carry junk in the
   // upper half, which the block must ignore.
   task automatic send_random_number;
      logic               hex_mode;
      logic [VALUE_W-1:0] number;
      hex_mode = $urandom_range(1, 0);
      if (hex_mode) begin
         number = {$urandom, $urandom} >> $urandom_range(63, 0);
      end else begin
         number[31:0]  = $urandom >> $urandom_range(31, 0);
         number[63:32] = $urandom_range(1, 0) ? $urandom : 32'h0;
      end
      send_number(hex_mode, number);
   endtask

   // Zero in both formats, the widest values, digit count boundaries and
   // decimal words whose upper half must be dropped.
   task automatic test_directed;
      send_number(FMT_DEC, 64'd0);
      send_number(FMT_HEX, 64'd0);
      send_number(FMT_DEC, 64'h0000_0000_FFFF_FFFF);
      send_number(FMT_HEX, 64'hFFFF_FFFF_FFFF_FFFF);
      send_number(FMT_DEC, 64'hFFFF_FFFF_0000_0000);
      send_number(FMT_DEC, 64'hFFFF_FFFF_FFFF_FFFF);
      send_number(FMT_DEC, 64'h0000_0001_0000_0007);
      send_number(FMT_DEC, 64'd9);
      send_number(FMT_DEC, 64'd10);
      send_number(FMT_DEC, 64'd999_999_999);
      send_number(FMT_DEC, 64'd1_000_000_000);
      send_number(FMT_HEX, 64'hF);
      send_number(FMT_HEX, 64'h10);
      send_number(FMT_HEX, 64'h8000_0000_0000_0000);
      send_number(FMT_HEX, 64'h0123_4567_89AB_CDEF);
      send_number(FMT_HEX, 64'hFEDC_BA98_7654_3210);
      send_number(FMT_HEX, 64'h0000_0000_FFFF_FFFF);
      send_number(FMT_DEC, 64'h5555_5555_AAAA_AAAA);
      send_number(FMT_HEX, 64'hAAAA_AAAA_5555_5555);
   endtask

   task automatic test_random_mix(input int count);
      repeat (count) send_random_number();
   endtask

   // Hold the result side for a long stretch while words keep coming, so the
   // block backs up and stalls its input.
   task automatic test_result_hold;
      rsp_hold_left = 300;
      repeat (4) send_random_number();
   endtask

   // A long run with no gaps on either side.
   task automatic test_steady_stream;
      send_gaps_on  = 1'b0;
      stall_gaps_on = 1'b0;
      repeat (40) send_random_number();
      send_gaps_on  = 1'b1;
      stall_gaps_on = 1'b1;
   endtask

   // Let the block run dry before sending again.
   task automatic test_pause_until_empty;
      repeat (3) send_random_number();
      release_input();
      wait_all_digits();
      repeat (3) send_random_number();
   endtask

   // Result side stall: a counted hold when requested, otherwise random.
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left--;
      end else begin
         rsp_stall <= stall_gaps_on && ($urandom_range(99) < 19);
      end
   end

   // Compare every accepted result word with the oldest queued digit.
   always @(posedge clock) begin
      digit_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_digits.size() == 0) begin
            digit_mismatches++;
            if (digit_mismatches <= 10)
               $display("unexpected digit word: char %h last %b",
                        rsp_digit_char, rsp_last_digit);
         end else begin
            want = pending_digits.pop_front();
            if (want.ch !== rsp_digit_char || want.last !== rsp_last_digit) begin
               digit_mismatches++;
               if (digit_mismatches <= 10)
                  $display("digit mismatch: expected char %h last %b, got char %h last %b",
                           want.ch, want.last, rsp_digit_char, rsp_last_digit);
            end
         end
      end
   end

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_mix(100);
      test_result_hold();
      test_steady_stream();
      test_pause_until_empty();
      test_random_mix(100);
      release_input();
      wait_all_digits();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (digit_mismatches == 0 && pending_digits.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
